// File: rtl/rrba_pkg.sv
package rrba_pkg;

   localparam int RRBA_PORTS = 4;

   localparam int MODE_W   = 3;
   localparam int PORT_W   = 4;
   localparam int REASON_W = 3;
   localparam int TICK_W   = 32;
   localparam int FAIL_W   = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [MODE_W-1:0] MODE_REQUEST  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ACQUIRE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_COMPLETE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CANCEL   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DELAY  = 2'd1;

   localparam logic [TICK_W-1:0] BASE_DELAY_RESET = 32'd1;
   localparam logic [TICK_W-1:0] MAX_DELAY_RESET  = 32'd65536;
   localparam logic [FAIL_W-1:0] FAIL_MAX         = 6'd63;

   typedef struct packed {
      logic load;     // capture the accepted item
      logic exec;     // evaluate and commit the item
      logic bo_run;   // backoff unit iterating
   } ctl_cmd_type;

   typedef struct packed {
      logic need_bo;  // item needs a backoff value
      logic bo_done;  // backoff unit has its value this cycle
   } dp_status_type;

endpackage

// File: rtl/rrba_req_if.sv
interface rrba_req_if;
   import rrba_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [PORT_W-1:0]   port;
   logic [REASON_W-1:0] reason;
   logic                success;
   logic [TICK_W-1:0]   cur_tick;
   modport source (output valid, mode, port, reason, success, cur_tick, input ready);
   modport sink (input valid, mode, port, reason, success, cur_tick, output ready);
endinterface

// File: rtl/rrba_rsp_if.sv
interface rrba_rsp_if;
   import rrba_pkg::*;
   logic                valid;
   logic                ready;
   logic                ok;
   logic [PORT_W-1:0]   grant_port;
   logic [REASON_W-1:0] grant_reason;
   logic [TICK_W-1:0]   retry_delay;
   modport source (output valid, ok, grant_port, grant_reason, retry_delay, input ready);
   modport sink (input valid, ok, grant_port, grant_reason, retry_delay, output ready);
endinterface

// File: rtl/rrba_csr_if.sv
interface rrba_csr_if;
   import rrba_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TICK_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/rrba_ctrl.sv
module rrba_ctrl
   import rrba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_EXEC    = 4'b0010,
      S_BACKOFF = 4'b0100,
      S_DONE    = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.need_bo ? S_BACKOFF : S_DONE;
         end
         S_BACKOFF: begin
            cmd.bo_run = 1'b1;
            if (status.bo_done) state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted beat not executed next");
   a_bo_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BACKOFF && !status.bo_done) |=> (state_ff == S_BACKOFF))
      else $error("backoff left early");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("not idle after result beat");

endmodule

// File: rtl/rrba_dp.sv
module rrba_dp
   import rrba_pkg::*;
#(
   parameter int PORTS = RRBA_PORTS
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   output dp_status_type        status,
   input  logic [MODE_W-1:0]    in_mode,
   input  logic [PORT_W-1:0]    in_port,
   input  logic [REASON_W-1:0]  in_reason,
   input  logic                 in_success,
   input  logic [TICK_W-1:0]    in_cur_tick,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data,
   output logic                 out_ok,
   output logic [PORT_W-1:0]    out_grant_port,
   output logic [REASON_W-1:0]  out_grant_reason,
   output logic [TICK_W-1:0]    out_retry_delay
);

   localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam logic [PORT_W:0] PORTS_EXT = (PORT_W+1)'(PORTS);
   localparam logic [PIDX_W-1:0] LAST_PORT = PIDX_W'(PORTS - 1);

   // per-port state
   logic [PORTS-1:0]    pending_ff, pending_in;
   logic [PORTS-1:0]    waiting_ff, waiting_in;
   logic [REASON_W-1:0] reason_ff [PORTS];
   logic [REASON_W-1:0] reason_in [PORTS];
   logic [TICK_W-1:0]   tick_ff [PORTS];
   logic [TICK_W-1:0]   tick_in [PORTS];
   logic [FAIL_W-1:0]   fails_ff [PORTS];
   logic [FAIL_W-1:0]   fails_in [PORTS];
   logic                busy_ff, busy_in;
   logic [PIDX_W-1:0]   holder_ff, holder_in;
   logic [PIDX_W-1:0]   rot_ff, rot_in;

   logic [TICK_W-1:0]   base_ff, base_in, max_ff, max_in;

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [PORT_W-1:0]   port_ff, port_in;
   logic [REASON_W-1:0] rsn_ff, rsn_in;
   logic                succ_ff, succ_in;
   logic [TICK_W-1:0]   now_ff, now_in;

   logic                ok_ff, ok_in;
   logic [PORT_W-1:0]   gport_ff, gport_in;
   logic [REASON_W-1:0] greason_ff, greason_in;
   logic [TICK_W-1:0]   delay_ff, delay_in;

   logic [TICK_W-1:0]   bo_d_ff, bo_d_in;
   logic [FAIL_W-1:0]   bo_i_ff, bo_i_in;
   logic [FAIL_W-1:0]   bo_n_ff, bo_n_in;

   logic [PIDX_W-1:0]   pi;
   logic                pv, is_holder;
   logic [PORTS-1:0]    elig, elig_hi;
   logic [TICK_W-1:0]   diff [PORTS];
   logic [PIDX_W-1:0]   pick_hi, pick_lo, pick;
   logic                any_hi, any_el;
   logic [TICK_W-1:0]   ceil_v, bo_val;
   logic                bo_done;
   logic [FAIL_W-1:0]   fails_inc;

   assign pi        = port_ff[PIDX_W-1:0];
   assign pv        = ({1'b0, port_ff} < PORTS_EXT);
   assign is_holder = busy_ff && pv && (holder_ff == pi);
   assign fails_inc = (fails_ff[pi] == FAIL_MAX) ? FAIL_MAX : fails_ff[pi] + 1'b1;

   // rotating priority pick over eligible ports
   always_comb begin
      pick_hi = '0;
      pick_lo = '0;
      for (int p = 0; p < PORTS; p++) begin
         diff[p]    = now_ff - tick_ff[p];
         elig[p]    = pending_ff[p] && !(waiting_ff[p] && diff[p][TICK_W-1]);
         elig_hi[p] = elig[p] && (PIDX_W'(p) >= rot_ff);
      end
      for (int p = PORTS - 1; p >= 0; p--) begin
         if (elig_hi[p]) pick_hi = PIDX_W'(p);
         if (elig[p])    pick_lo = PIDX_W'(p);
      end
      any_hi = |elig_hi;
      any_el = |elig;
      pick   = any_hi ? pick_hi : pick_lo;
   end

   // one doubling step per cycle while the backoff unit runs
   always_comb begin
      ceil_v  = (max_ff < base_ff) ? base_ff : max_ff;
      bo_done = 1'b1;
      bo_val  = '0;
      bo_d_in = bo_d_ff;
      bo_i_in = bo_i_ff;
      if (bo_d_ff == '0) begin
         bo_val = '0;
      end else if (bo_i_ff >= bo_n_ff) begin
         bo_val = (bo_d_ff > ceil_v) ? ceil_v : bo_d_ff;
      end else if (bo_d_ff >= ceil_v || bo_d_ff[TICK_W-1]) begin
         bo_val = ceil_v;
      end else begin
         bo_done = 1'b0;
         if (cmd.bo_run) begin
            bo_d_in = {bo_d_ff[TICK_W-2:0], 1'b0};
            bo_i_in = bo_i_ff + 1'b1;
         end
      end
      bo_n_in = bo_n_ff;
      status.bo_done = bo_done;
      status.need_bo = ((mode_ff == MODE_COMPLETE) && is_holder && !succ_ff)
                    || ((mode_ff == MODE_QUERY) && pv && waiting_ff[pi]);
      if (cmd.exec && status.need_bo) begin
         bo_d_in = base_ff;
         bo_i_in = FAIL_W'(1);
         bo_n_in = (mode_ff == MODE_COMPLETE) ? fails_inc : fails_ff[pi];
      end
   end

   always_comb begin
      pending_in = pending_ff;
      waiting_in = waiting_ff;
      reason_in  = reason_ff;
      tick_in    = tick_ff;
      fails_in   = fails_ff;
      busy_in    = busy_ff;
      holder_in  = holder_ff;
      rot_in     = rot_ff;
      ok_in      = ok_ff;
      gport_in   = gport_ff;
      greason_in = greason_ff;
      delay_in   = delay_ff;
      base_in    = base_ff;
      max_in     = max_ff;
      mode_in    = mode_ff;
      port_in    = port_ff;
      rsn_in     = rsn_ff;
      succ_in    = succ_ff;
      now_in     = now_ff;

      if (csr_we) begin
         case (csr_index)
            REG_BASE_DELAY: base_in = csr_data;
            REG_MAX_DELAY:  max_in  = csr_data;
            default: ;
         endcase
      end

      if (cmd.load) begin
         mode_in = in_mode;
         port_in = in_port;
         rsn_in  = in_reason;
         succ_in = in_success;
         now_in  = in_cur_tick;
      end

      if (cmd.exec) begin
         ok_in      = 1'b0;
         gport_in   = '0;
         greason_in = '0;
         delay_in   = '0;
         case (mode_ff)
            MODE_REQUEST: begin
               if (pv && rsn_ff != '0) begin
                  ok_in = 1'b1;
                  if (pending_ff[pi] || is_holder) begin
                     if (rsn_ff > reason_ff[pi]) reason_in[pi] = rsn_ff;
                  end else begin
                     pending_in[pi] = 1'b1;
                     waiting_in[pi] = 1'b0;
                     reason_in[pi]  = rsn_ff;
                     tick_in[pi]    = '0;
                  end
               end
            end
            MODE_ACQUIRE: begin
               if (!busy_ff && any_el) begin
                  pending_in[pick] = 1'b0;
                  waiting_in[pick] = 1'b0;
                  busy_in          = 1'b1;
                  holder_in        = pick;
                  rot_in           = (pick == LAST_PORT) ? '0 : pick + 1'b1;
                  ok_in            = 1'b1;
                  gport_in         = PORT_W'(pick);
                  greason_in       = reason_ff[pick];
               end
            end
            MODE_COMPLETE: begin
               if (is_holder) begin
                  busy_in = 1'b0;
                  ok_in   = 1'b1;
                  if (succ_ff) begin
                     pending_in[pi] = 1'b0;
                     waiting_in[pi] = 1'b0;
                     reason_in[pi]  = '0;
                     tick_in[pi]    = '0;
                     fails_in[pi]   = '0;
                  end else begin
                     fails_in[pi]   = fails_inc;
                     pending_in[pi] = 1'b1;
                     waiting_in[pi] = 1'b1;
                  end
               end
            end
            MODE_CANCEL: begin
               if (pv && !is_holder) begin
                  pending_in[pi] = 1'b0;
                  waiting_in[pi] = 1'b0;
                  reason_in[pi]  = '0;
                  tick_in[pi]    = '0;
                  fails_in[pi]   = '0;
                  ok_in          = 1'b1;
               end
            end
            MODE_QUERY: begin
               if (pv && waiting_ff[pi]) ok_in = 1'b1;
            end
            default: ;
         endcase
      end

      // deadline or queried delay once the backoff value is known
      if (cmd.bo_run && bo_done) begin
         if (mode_ff == MODE_QUERY) delay_in = bo_val;
         else                       tick_in[pi] = now_ff + bo_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         waiting_ff <= '0;
         busy_ff    <= 1'b0;
         holder_ff  <= '0;
         rot_ff     <= '0;
         base_ff    <= BASE_DELAY_RESET;
         max_ff     <= MAX_DELAY_RESET;
         for (int p = 0; p < PORTS; p++) begin
            reason_ff[p] <= '0;
            tick_ff[p]   <= '0;
            fails_ff[p]  <= '0;
         end
      end else begin
         pending_ff <= pending_in;
         waiting_ff <= waiting_in;
         busy_ff    <= busy_in;
         holder_ff  <= holder_in;
         rot_ff     <= rot_in;
         base_ff    <= base_in;
         max_ff     <= max_in;
         reason_ff  <= reason_in;
         tick_ff    <= tick_in;
         fails_ff   <= fails_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      port_ff    <= port_in;
      rsn_ff     <= rsn_in;
      succ_ff    <= succ_in;
      now_ff     <= now_in;
      ok_ff      <= ok_in;
      gport_ff   <= gport_in;
      greason_ff <= greason_in;
      delay_ff   <= delay_in;
      bo_d_ff    <= bo_d_in;
      bo_i_ff    <= bo_i_in;
      bo_n_ff    <= bo_n_in;
   end

   assign out_ok           = ok_ff;
   assign out_grant_port   = gport_ff;
   assign out_grant_reason = greason_ff;
   assign out_retry_delay  = delay_ff;

   a_wait_pending: assert property (@(posedge clock) disable iff (reset)
      !(|(waiting_ff & ~pending_ff)))
      else $error("port waiting without pending");
   a_holder_clear: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !pending_ff[holder_ff])
      else $error("active holder still pending");
   a_grant_src: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(cmd.exec && mode_ff == MODE_ACQUIRE))
      else $error("grant outside acquire");

endmodule

// File: rtl/recovery_round_robin_backoff_arbiter.sv
// recovery arbiter: ports raise recovery requests with a severity reason, an
// acquire beat grants one pending port at a time in round-robin order, and a
// failed completion puts the port back with an exponential retry deadline
// (base_delay doubled per failure, capped at max(max_delay, base_delay)).
// every request beat gives exactly one result beat. an item goes through
// capture, execute and the result register plus, for a failed completion
// or a delay query, the doubling steps of the backoff unit and a final step
// to settle the value. one item is in flight at a time; the result
// register holds until the result beat is taken. csr writes are always
// taken and must only happen while the block is idle.
module recovery_round_robin_backoff_arbiter
   import rrba_pkg::*;
#(
   parameter int PORTS = RRBA_PORTS
)
(
   input logic        clock,
   input logic        reset,
   rrba_req_if.sink   req_bus,
   rrba_rsp_if.source rsp_bus,
   rrba_csr_if.sink   csr_bus
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // configuration port never stalls
   assign csr_bus.ready = 1'b1;

   // sequencer: capture, execute, backoff iterations, result beat
   rrba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // per-port state, round-robin pick, backoff unit and result register
   rrba_dp #(
      .PORTS (PORTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_mode          (req_bus.mode),
      .in_port          (req_bus.port),
      .in_reason        (req_bus.reason),
      .in_success       (req_bus.success),
      .in_cur_tick      (req_bus.cur_tick),
      .csr_we           (csr_bus.valid),
      .csr_index        (csr_bus.index),
      .csr_data         (csr_bus.data),
      .out_ok           (rsp_bus.ok),
      .out_grant_port   (rsp_bus.grant_port),
      .out_grant_reason (rsp_bus.grant_reason),
      .out_retry_delay  (rsp_bus.retry_delay)
   );

endmodule

// File: test/recovery_round_robin_backoff_arbiter_tb.sv
module recovery_round_robin_backoff_arbiter_tb;
   import rrba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 600000;
   // longest item: the pipeline states plus the backoff iterations
   localparam int SETTLE_CYCLES = 48;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [PORT_W-1:0]   port;
      logic [REASON_W-1:0] reason;
      logic                success;
      logic [TICK_W-1:0]   cur_tick;
   } arb_op_t;

   typedef struct packed {
      logic                ok;
      logic [PORT_W-1:0]   grant_port;
      logic [REASON_W-1:0] grant_reason;
      logic [TICK_W-1:0]   retry_delay;
   } arb_result_t;

   localparam int OP_W = $bits(arb_op_t);

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrba_req_if req_bus ();
   rrba_rsp_if rsp_bus ();
   rrba_csr_if csr_bus ();

   recovery_round_robin_backoff_arbiter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the arbiter state
   logic [TICK_W-1:0]   base_delay_q, max_delay_q;
   logic                pend_q     [RRBA_PORTS];
   logic                waiting_q  [RRBA_PORTS];
   logic [REASON_W-1:0] reason_q   [RRBA_PORTS];
   logic [TICK_W-1:0]   deadline_q [RRBA_PORTS];
   logic [FAIL_W-1:0]   fails_q    [RRBA_PORTS];
   logic                busy_q;
   int unsigned         holder_q, rotate_q;

   arb_result_t expected_results[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          rx_hold_left = 0;
   logic [TICK_W-1:0] tick_now = '0;

   function automatic logic [TICK_W-1:0] retry_backoff(logic [FAIL_W-1:0] fails);
      logic [TICK_W-1:0] ceil_d, d;
      ceil_d = (max_delay_q < base_delay_q) ? base_delay_q : max_delay_q;
      d = base_delay_q;
      if (d == '0) return '0;
      for (int i = 1; i < fails; i++) begin
         if (d >= ceil_d || d[TICK_W-1]) return ceil_d;
         d = d << 1;
      end
      return (d > ceil_d) ? ceil_d : d;
   endfunction

   task automatic clear_shadow_port(int unsigned p);
      pend_q[p] = 1'b0;
      waiting_q[p] = 1'b0;
      reason_q[p] = '0;
      deadline_q[p] = '0;
      fails_q[p] = '0;
   endtask

   // apply one accepted beat to the shadow state and queue its result
   task automatic predict_arbitration(arb_op_t op);
      arb_result_t r;
      logic port_in_range, is_holder;
      logic [TICK_W-1:0] diff;
      int unsigned p;
      r = '0;
      port_in_range = op.port < RRBA_PORTS;
      is_holder = busy_q && holder_q == op.port;
      case (op.mode)
         MODE_REQUEST: if (port_in_range && op.reason != '0) begin
            r.ok = 1'b1;
            if (pend_q[op.port] || is_holder) begin
               if (op.reason > reason_q[op.port]) reason_q[op.port] = op.reason;
            end else begin
               pend_q[op.port] = 1'b1;
               waiting_q[op.port] = 1'b0;
               reason_q[op.port] = op.reason;
               deadline_q[op.port] = '0;
            end
         end
         MODE_ACQUIRE: if (!busy_q) begin
            for (int off = 0; off < RRBA_PORTS; off++) begin
               p = (rotate_q + off) % RRBA_PORTS;
               diff = op.cur_tick - deadline_q[p];
               // waiting ports need a non-negative wrapped distance
               if (pend_q[p] && !(waiting_q[p] && diff[TICK_W-1])) begin
                  pend_q[p] = 1'b0;
                  waiting_q[p] = 1'b0;
                  busy_q = 1'b1;
                  holder_q = p;
                  rotate_q = (p + 1) % RRBA_PORTS;
                  r.ok = 1'b1;
                  r.grant_port = p[PORT_W-1:0];
                  r.grant_reason = reason_q[p];
                  break;
               end
            end
         end
         MODE_COMPLETE: if (port_in_range && is_holder) begin
            busy_q = 1'b0;
            r.ok = 1'b1;
            if (op.success) clear_shadow_port(32'(op.port));
            else begin
               if (fails_q[op.port] != FAIL_MAX) fails_q[op.port]++;
               pend_q[op.port] = 1'b1;
               waiting_q[op.port] = 1'b1;
               deadline_q[op.port] = op.cur_tick + retry_backoff(fails_q[op.port]);
            end
         end
         MODE_CANCEL: if (port_in_range && !is_holder) begin
            clear_shadow_port(32'(op.port));
            r.ok = 1'b1;
         end
         MODE_QUERY: if (port_in_range && waiting_q[op.port]) begin
            r.ok = 1'b1;
            r.retry_delay = retry_backoff(fails_q[op.port]);
         end
         default: ;
      endcase
      expected_results.push_back(r);
   endtask

   // one request beat, with an optional random gap in front
   task automatic send_op(arb_op_t op);
      int gap;
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= op.mode;
      req_bus.port     <= op.port;
      req_bus.reason   <= op.reason;
      req_bus.success  <= op.success;
      req_bus.cur_tick <= op.cur_tick;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_arbitration(op);
   endtask

   task automatic send_fields(logic [MODE_W-1:0] mode, logic [PORT_W-1:0] port,
                              logic [REASON_W-1:0] reason, logic success,
                              logic [TICK_W-1:0] cur_tick);
      arb_op_t op;
      op = '{mode, port, reason, success, cur_tick};
      send_op(op);
   endtask

   // stop offering and wait until every result beat has come back
   task automatic drain;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [TICK_W-1:0] value);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (index == REG_BASE_DELAY) base_delay_q = value;
      else if (index == REG_MAX_DELAY) max_delay_q = value;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: random stalls, or a long hold-off while rx_hold_left runs down
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left <= rx_hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= $urandom_range(99) >= rx_idle_pct;
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      arb_result_t want, got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.ok, rsp_bus.grant_port, rsp_bus.grant_reason, rsp_bus.retry_delay};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, got);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.ok !== want.ok) begin
               $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
               fail_count++;
            end
            if (got.grant_port !== want.grant_port) begin
               $display("%0t: grant_port expected %0d actual %0d", $time,
                        want.grant_port, got.grant_port);
               fail_count++;
            end
            if (got.grant_reason !== want.grant_reason) begin
               $display("%0t: grant_reason expected %0d actual %0d", $time,
                        want.grant_reason, got.grant_reason);
               fail_count++;
            end
            if (got.retry_delay !== want.retry_delay) begin
               $display("%0t: retry_delay expected %h actual %h", $time,
                        want.retry_delay, got.retry_delay);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("recovery_round_robin_backoff_arbiter_tb failed");
         $finish;
      end
   end

   // corner beats: every mode, bad ports and reasons, coalescing, busy paths,
   // deadline compare across the wrap point
   task automatic test_directed;
      send_fields(MODE_REQUEST, 4'd15, 3'd7, 1'b0, 32'hFFFF_FFFF);   // bad port
      send_fields(MODE_REQUEST, 4'd1, 3'd0, 1'b0, '0);              // reason none
      send_fields(MODE_ACQUIRE, 4'd0, 3'd0, 1'b0, '0);              // nothing pending
      send_fields(MODE_REQUEST, 4'd1, 3'd2, 1'b0, '0);
      send_fields(MODE_REQUEST, 4'd1, 3'd5, 1'b0, '0);              // coalesce, raise
      send_fields(MODE_REQUEST, 4'd1, 3'd3, 1'b0, '0);              // coalesce, keep
      send_fields(MODE_REQUEST, 4'd3, 3'd7, 1'b1, '0);
      send_fields(MODE_ACQUIRE, 4'd9, 3'd0, 1'b0, '0);
      send_fields(MODE_ACQUIRE, 4'd0, 3'd0, 1'b0, '0);              // busy
      send_fields(MODE_REQUEST, 4'd1, 3'd6, 1'b0, '0);              // on the holder
      send_fields(MODE_CANCEL, 4'd1, 3'd0, 1'b0, '0);               // holder refused
      send_fields(MODE_COMPLETE, 4'd3, 3'd0, 1'b0, '0);             // not holder
      send_fields(MODE_COMPLETE, 4'd1, 3'd0, 1'b0, 32'hFFFF_FFFE);  // fail across wrap
      send_fields(MODE_QUERY, 4'd1, 3'd0, 1'b0, '0);
      send_fields(MODE_QUERY, 4'd3, 3'd0, 1'b0, '0);                // not waiting
      send_fields(MODE_QUERY, 4'd12, 3'd0, 1'b0, '0);
      send_fields(MODE_ACQUIRE, 4'd0, 3'd0, 1'b0, 32'hFFFF_FFFE);   // port 3 ready first
      send_fields(MODE_COMPLETE, 4'd3, 3'd0, 1'b1, '0);
      send_fields(MODE_ACQUIRE, 4'd0, 3'd0, 1'b0, 32'hFFFF_FFFE);   // port 1 not due
      send_fields(MODE_ACQUIRE, 4'd0, 3'd0, 1'b0, 32'hFFFF_FFFF);   // port 1 due
      send_fields(MODE_COMPLETE, 4'd1, 3'd0, 1'b1, '0);
      send_fields(MODE_CANCEL, 4'd14, 3'd0, 1'b0, '0);
      send_fields(MODE_CANCEL, 4'd2, 3'd0, 1'b0, '0);
      for (int m = MODE_QUERY + 1; m < (1 << MODE_W); m++)
         send_fields(m[MODE_W-1:0], 4'd0, 3'd7, 1'b1, 32'hFFFF_FFFF);  // unused modes
   endtask

   // mostly well-formed recovery traffic, some noise
   task automatic run_traffic(int count);
      arb_op_t op;
      int pick;
      for (int n = 0; n < count; n++) begin
         op = '0;
         tick_now += ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 6);
         op.cur_tick = ($urandom_range(19) == 0) ? $urandom() : tick_now;
         pick = $urandom_range(99);
         op.port = PORT_W'($urandom_range(0, RRBA_PORTS - 1));
         if (pick < 25) begin
            op.mode = MODE_REQUEST;
            op.reason = REASON_W'($urandom_range(1, 7));
         end else if (pick < 45) begin
            op.mode = MODE_ACQUIRE;
         end else if (pick < 70) begin
            op.mode = MODE_COMPLETE;
            if (busy_q && $urandom_range(9) != 0) op.port = PORT_W'(holder_q);
            op.success = $urandom_range(3) == 0;
         end else if (pick < 82) begin
            op.mode = MODE_QUERY;
         end else if (pick < 87) begin
            op.mode = MODE_CANCEL;
         end else begin
            op = OP_W'({$urandom(), $urandom()});
            op.mode = MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
         end
         send_op(op);
      end
   endtask

   // register settings, extremes included, each with repeated failures
   task automatic test_register_sweep;
      logic [TICK_W-1:0] settings[6][2] = '{
         '{32'd0, 32'd100},                  // backoff disabled
         '{32'd7, 32'd0},                    // base above ceiling
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
         '{32'h8000_0000, 32'd3},
         '{32'd3, 32'hFFFF_FFFF},            // doubling until the top bit
         '{BASE_DELAY_RESET, MAX_DELAY_RESET}
      };
      for (int s = 0; s < 6; s++) begin
         write_reg(REG_BASE_DELAY, settings[s][0]);
         write_reg(REG_MAX_DELAY, settings[s][1]);
         send_fields(MODE_REQUEST, 4'd2, 3'd4, 1'b0, tick_now);
         for (int k = 0; k < 20; k++) begin
            // keep failing port 2 so its count climbs toward saturation
            send_fields(MODE_ACQUIRE, 4'd0, 3'd0, 1'b0, tick_now ^ 32'h8000_0000);
            if (busy_q) send_fields(MODE_COMPLETE, holder_q[PORT_W-1:0], 3'd0, 1'b0, tick_now);
            send_fields(MODE_QUERY, 4'd2, 3'd0, 1'b0, tick_now);
         end
         run_traffic(20);
      end
   endtask

   task automatic test_random_idling;
      tx_idle_pct = 7;  rx_idle_pct = 73;
      run_traffic(150);
      tx_idle_pct = 73; rx_idle_pct = 7;
      run_traffic(150);
      tx_idle_pct = 0;  rx_idle_pct = 0;
      run_traffic(150);
   endtask

   // receiver holds off while the sender keeps offering, then a full pause
   task automatic test_backpressure;
      rx_hold_left = 300;
      run_traffic(30);
      drain();
      run_traffic(10);
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_REQUEST;
      req_bus.port <= '0;
      req_bus.reason <= '0;
      req_bus.success <= 1'b0;
      req_bus.cur_tick <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_BASE_DELAY;
      csr_bus.data <= '0;
      base_delay_q = BASE_DELAY_RESET;
      max_delay_q = MAX_DELAY_RESET;
      for (int p = 0; p < RRBA_PORTS; p++) clear_shadow_port(p);
      busy_q = 1'b0;
      holder_q = 0;
      rotate_q = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_sweep();
      test_random_idling();
      test_backpressure();
      drain();

      if (fail_count == 0) begin
         $display("recovery_round_robin_backoff_arbiter_tb passed");
      end else begin
         $display("recovery_round_robin_backoff_arbiter_tb failed");
      end
      $finish;
   end

endmodule
